/* rtl/hed_pkg.sv */
package hed_pkg;

	localparam int MAX_BODY_LEN = 16;
	localparam int LEN_W = $clog2(MAX_BODY_LEN + 1);
	// replay window is sized for the body and two more bytes, the byte that ended it among them
	localparam int AW = $clog2(MAX_BODY_LEN + 2);
	localparam int DEPTH = 1 << AW;

	localparam int CP_W = 21;
	localparam logic [CP_W-1:0] CP_LIMIT = 21'h10FFFF;
	localparam logic [CP_W-1:0] CP_SAT = 21'h110000;

	localparam logic [7:0] AMP_CH = 8'h26;
	localparam logic [7:0] SEMI_CH = 8'h3B;
	localparam logic [7:0] HASH_CH = 8'h23;

	localparam int NM_CNT = 5;
	localparam logic [7:0] NM_CHR [NM_CNT][4] = '{
		'{"a", "m", "p", 8'h00},
		'{"l", "t", 8'h00, 8'h00},
		'{"g", "t", 8'h00, 8'h00},
		'{"q", "u", "o", "t"},
		'{"a", "p", "o", "s"}
	};
	localparam int NM_LEN [NM_CNT] = '{3, 2, 2, 4, 4};
	localparam logic [7:0] NM_REP [NM_CNT] = '{8'h26, 8'h3C, 8'h3E, 8'h22, 8'h27};

	// output byte select
	localparam logic [1:0] EM_CUR = 2'd0;
	localparam logic [1:0] EM_AMP = 2'd1;
	localparam logic [1:0] EM_REP = 2'd2;

	typedef struct packed {
		logic       accept;
		logic       fetch;
		logic       start_ref;
		logic       store;
		logic       advance;
		logic       fail;
		logic       resolve;
		logic       rep_next;
		logic       flush_start;
		logic       end_flush;
		logic       emit;
		logic [1:0] emit_sel;
		logic       emit_last;
	} hed_cmd_t;

	typedef struct packed {
		logic pending;
		logic cur_amp;
		logic cur_semi;
		logic body_full;
		logic resolve_ok;
		logic q_end;
		logic q_end_next;
		logic flush_empty;
		logic rep_done;
		logic out_free;
		logic last;
	} hed_sts_t;

	typedef struct packed {
		logic [3:0][7:0] b;
		logic [1:0]      n_m1;
	} rep_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} digit_t;

	function automatic logic [NM_CNT-1:0] name_hits(logic [LEN_W-1:0] pos, logic [7:0] b);
		logic [NM_CNT-1:0] h;
		h = '0;
		for (int i = 0; i < NM_CNT; i++) begin
			h[i] = (int'(pos) < NM_LEN[i]) && (b == NM_CHR[i][pos[1:0]]);
		end
		return h;
	endfunction

	function automatic digit_t digit_val(logic [7:0] c, logic hex);
		digit_t d;
		d.ok = 1'b0;
		d.val = '0;
		if (c >= "0" && c <= "9") begin
			d.ok = 1'b1;
			d.val = 4'(c - "0");
		end else if (hex && c >= "a" && c <= "f") begin
			d.ok = 1'b1;
			d.val = 4'(c - "a" + 8'd10);
		end else if (hex && c >= "A" && c <= "F") begin
			d.ok = 1'b1;
			d.val = 4'(c - "A" + 8'd10);
		end
		return d;
	endfunction

	function automatic rep_t utf8_enc(logic [CP_W-1:0] cp);
		rep_t r;
		r.b = '0;
		if (cp <= 21'h7F) begin
			r.n_m1 = 2'd0;
			r.b[0] = cp[7:0];
		end else if (cp <= 21'h7FF) begin
			r.n_m1 = 2'd1;
			r.b[0] = 8'hC0 | {3'b000, cp[10:6]};
			r.b[1] = 8'h80 | {2'b00, cp[5:0]};
		end else if (cp <= 21'hFFFF) begin
			r.n_m1 = 2'd2;
			r.b[0] = 8'hE0 | {4'b0000, cp[15:12]};
			r.b[1] = 8'h80 | {2'b00, cp[11:6]};
			r.b[2] = 8'h80 | {2'b00, cp[5:0]};
		end else begin
			r.n_m1 = 2'd3;
			r.b[0] = 8'hF0 | {5'b00000, cp[20:18]};
			r.b[1] = 8'h80 | {2'b00, cp[17:12]};
			r.b[2] = 8'h80 | {2'b00, cp[11:6]};
			r.b[3] = 8'h80 | {2'b00, cp[5:0]};
		end
		return r;
	endfunction

endpackage

/* rtl/html_entity_decoder.sv */
// plain bytes: no new input beat is taken until the current one is consumed; the beat is registered
// as the current byte, then in the output register; the byte buffer read port sets the replay pace
// ';' of a resolved reference: the replacement is emitted one output byte at a time (1 to 4 bytes)
// failed reference or end-of-string flush: the '&' is emitted first, then each held byte in turn,
// one buffer read per held byte before its emit; a stalled output holds each emit until it drains
// arst_n clears the controller, pointers and output valid; the byte buffer is not cleared
module html_entity_decoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [7:0] in_byte
	input  logic       s_axis_tlast,
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // [7:0] out_byte
	output logic       m_axis_tlast
);

	hed_pkg::hed_cmd_t cmd;
	hed_pkg::hed_sts_t sts;

	hed_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	hed_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_byte   (s_axis_tdata),
		.in_last   (s_axis_tlast),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_byte  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule

/* rtl/hed_ctrl.sv */
module hed_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  hed_pkg::hed_sts_t sts,
	output hed_pkg::hed_cmd_t cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_PROC   = 3'd1;
	localparam logic [2:0] S_FETCH  = 3'd2;
	localparam logic [2:0] S_REP    = 3'd3;
	localparam logic [2:0] S_FAMP   = 3'd4;
	localparam logic [2:0] S_FFETCH = 3'd5;
	localparam logic [2:0] S_FEMIT  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// where to go once the current byte is consumed
	function automatic logic [2:0] after_byte(logic pend, hed_pkg::hed_sts_t s);
		logic [2:0] n;
		if (!s.q_end_next) begin
			n = S_FETCH;
		end else if (s.last && pend) begin
			n = S_FAMP;
		end else begin
			n = S_IDLE;
		end
		return n;
	endfunction

	always_comb begin
		cmd = '0;
		state_d = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d = S_PROC;
				end
			end
			S_PROC: begin
				if (!sts.pending) begin
					if (sts.cur_amp) begin
						cmd.start_ref = 1'b1;
						cmd.advance = 1'b1;
						state_d = after_byte(1'b1, sts);
					end else if (sts.out_free) begin
						cmd.emit = 1'b1;
						cmd.emit_sel = hed_pkg::EM_CUR;
						cmd.emit_last = sts.last && sts.q_end_next;
						cmd.advance = 1'b1;
						state_d = after_byte(1'b0, sts);
					end
				end else if (sts.cur_semi && sts.resolve_ok) begin
					cmd.resolve = 1'b1;
					cmd.advance = 1'b1;
					state_d = S_REP;
				end else if (!sts.cur_semi && !sts.body_full) begin
					cmd.store = 1'b1;
					cmd.advance = 1'b1;
					state_d = after_byte(1'b1, sts);
				end else if (sts.out_free) begin
					// failed reference: literal '&', then rescan from the body start
					cmd.emit = 1'b1;
					cmd.emit_sel = hed_pkg::EM_AMP;
					cmd.fail = 1'b1;
					state_d = S_FETCH;
				end
			end
			S_FETCH: begin
				cmd.fetch = 1'b1;
				state_d = S_PROC;
			end
			S_REP: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.emit_sel = hed_pkg::EM_REP;
					cmd.emit_last = sts.rep_done && sts.last && sts.q_end;
					cmd.rep_next = 1'b1;
					if (sts.rep_done) begin
						state_d = sts.q_end ? S_IDLE : S_FETCH;
					end
				end
			end
			S_FAMP: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.emit_sel = hed_pkg::EM_AMP;
					cmd.emit_last = sts.flush_empty;
					cmd.flush_start = 1'b1;
					if (sts.flush_empty) begin
						cmd.end_flush = 1'b1;
						state_d = S_IDLE;
					end else begin
						state_d = S_FFETCH;
					end
				end
			end
			S_FFETCH: begin
				cmd.fetch = 1'b1;
				state_d = S_FEMIT;
			end
			S_FEMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.emit_sel = hed_pkg::EM_CUR;
					cmd.emit_last = sts.q_end_next;
					cmd.advance = 1'b1;
					if (sts.q_end_next) begin
						cmd.end_flush = 1'b1;
						state_d = S_IDLE;
					end else begin
						state_d = S_FFETCH;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* rtl/hed_dp.sv */
module hed_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  hed_pkg::hed_cmd_t cmd,
	output hed_pkg::hed_sts_t sts,
	input  logic [7:0]        in_byte,
	input  logic              in_last,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        out_byte,
	output logic              out_last
);

	logic [7:0] mem [hed_pkg::DEPTH];
	logic [7:0] cur_q;

	logic [hed_pkg::AW-1:0] p_q;
	logic [hed_pkg::AW-1:0] s_q;
	logic [hed_pkg::AW-1:0] tail_q;
	logic [hed_pkg::AW-1:0] p_inc;
	logic                   pending_q;
	logic                   last_q;

	// reference body trackers
	logic [hed_pkg::LEN_W-1:0]  len_q;
	logic [hed_pkg::NM_CNT-1:0] nm_q;
	logic                       hash_q;
	logic                       hex_q;
	logic                       num_ok_q;
	logic                       have_dig_q;
	logic [hed_pkg::CP_W-1:0]   cp_q;

	hed_pkg::rep_t   rep_q;
	logic [1:0]      k_q;

	logic                 out_valid_q;
	logic [7:0]           out_byte_q;
	logic                 out_last_q;

	hed_pkg::digit_t          dig;
	logic [hed_pkg::CP_W+3:0] cp_ext;
	logic [hed_pkg::CP_W+3:0] cp_mul;
	logic [hed_pkg::CP_W+3:0] cp_sum;
	logic [hed_pkg::CP_W-1:0] cp_next;
	logic [hed_pkg::NM_CNT-1:0] nm_full;
	logic                     name_ok;
	logic                     num_ok;
	hed_pkg::rep_t            rep_d;
	logic [7:0]               emit_byte;

	assign p_inc = p_q + 1'b1;

	always_comb begin
		dig = hed_pkg::digit_val(cur_q, hex_q);
		cp_ext = {4'b0000, cp_q};
		cp_mul = hex_q ? (cp_ext << 4) : ((cp_ext << 3) + (cp_ext << 1));
		cp_sum = cp_mul + {{(hed_pkg::CP_W){1'b0}}, dig.val};
		if (cp_sum > {4'b0000, hed_pkg::CP_LIMIT}) begin
			cp_next = hed_pkg::CP_SAT;
		end else begin
			cp_next = cp_sum[hed_pkg::CP_W-1:0];
		end
	end

	always_comb begin
		for (int i = 0; i < hed_pkg::NM_CNT; i++) begin
			nm_full[i] = nm_q[i] && (len_q == hed_pkg::LEN_W'(hed_pkg::NM_LEN[i]));
		end
		name_ok = |nm_full;
		num_ok = hash_q && num_ok_q && have_dig_q && (cp_q <= hed_pkg::CP_LIMIT);
		if (name_ok) begin
			rep_d.b = '0;
			rep_d.n_m1 = 2'd0;
			for (int i = 0; i < hed_pkg::NM_CNT; i++) begin
				if (nm_full[i]) begin
					rep_d.b[0] = hed_pkg::NM_REP[i];
				end
			end
		end else begin
			rep_d = hed_pkg::utf8_enc(cp_q);
		end
	end

	always_comb begin
		sts.pending = pending_q;
		sts.cur_amp = cur_q == hed_pkg::AMP_CH;
		sts.cur_semi = cur_q == hed_pkg::SEMI_CH;
		sts.body_full = len_q == hed_pkg::LEN_W'(hed_pkg::MAX_BODY_LEN);
		sts.resolve_ok = name_ok || num_ok;
		sts.q_end = p_q == tail_q;
		sts.q_end_next = p_inc == tail_q;
		sts.flush_empty = s_q == tail_q;
		sts.rep_done = k_q == rep_q.n_m1;
		sts.out_free = !out_valid_q || out_ready;
		sts.last = last_q;
	end

	always_comb begin
		case (cmd.emit_sel)
			hed_pkg::EM_AMP: emit_byte = hed_pkg::AMP_CH;
			hed_pkg::EM_REP: emit_byte = rep_q.b[k_q];
			default:         emit_byte = cur_q;
		endcase
	end

	// byte buffer: input beats land at tail, replay reads at p
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			mem[tail_q] <= in_byte;
			cur_q <= in_byte;
		end else if (cmd.fetch) begin
			cur_q <= mem[p_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q <= '0;
			s_q <= '0;
			tail_q <= '0;
			pending_q <= 1'b0;
			last_q <= 1'b0;
			len_q <= '0;
			k_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				tail_q <= tail_q + 1'b1;
				last_q <= in_last;
			end
			if (cmd.advance) begin
				p_q <= p_inc;
			end
			if (cmd.fail || cmd.flush_start) begin
				p_q <= s_q;
			end
			if (cmd.start_ref) begin
				pending_q <= 1'b1;
				s_q <= p_inc;
				len_q <= '0;
			end
			if (cmd.store) begin
				len_q <= len_q + 1'b1;
			end
			if (cmd.fail || cmd.resolve || cmd.end_flush) begin
				pending_q <= 1'b0;
			end
			if (cmd.resolve) begin
				k_q <= '0;
			end else if (cmd.rep_next) begin
				k_q <= k_q + 1'b1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_ref) begin
			nm_q <= '1;
			hash_q <= 1'b0;
			hex_q <= 1'b0;
			num_ok_q <= 1'b1;
			have_dig_q <= 1'b0;
			cp_q <= '0;
		end else if (cmd.store) begin
			nm_q <= nm_q & hed_pkg::name_hits(len_q, cur_q);
			if (len_q == '0) begin
				hash_q <= cur_q == hed_pkg::HASH_CH;
			end else if (len_q == hed_pkg::LEN_W'(1) && (cur_q == "x" || cur_q == "X")) begin
				hex_q <= 1'b1;
			end else if (!dig.ok) begin
				num_ok_q <= 1'b0;
			end else begin
				cp_q <= cp_next;
				have_dig_q <= 1'b1;
			end
		end
		if (cmd.resolve) begin
			rep_q <= rep_d;
		end
		if (cmd.emit) begin
			out_byte_q <= emit_byte;
			out_last_q <= cmd.emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte = out_byte_q;
	assign out_last = out_last_q;

endmodule
